>>> sv/spsl_pkg.sv
// ----------------------------------------------------------------------------
// spsl_pkg
// Shared constants and types for the segment prefix-sum locator.
// ----------------------------------------------------------------------------
package spsl_pkg;

   localparam int MAX_SEGMENTS_DEF = 1024;
   localparam int COUNT_WIDTH_DEF  = 32;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_LOCATE = 2'd1;
   localparam logic [1:0] OP_LEFT   = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_OVERFLOW = 3'd2;
   localparam logic [2:0] ST_PAST_END = 3'd3;
   localparam logic [2:0] ST_BAD_SEG  = 3'd4;

   typedef enum logic [3:0] {
      FSM_IDLE   = 4'b0001,
      FSM_SEARCH = 4'b0010,
      FSM_LOOKUP = 4'b0100,
      FSM_FINISH = 4'b1000
   } fsm_type;

endpackage

>>> sv/segment_prefix_sum_locator_unit.sv
// ----------------------------------------------------------------------------
// segment_prefix_sum_locator_unit
// Prefix-sum table of segment lengths with append, locate and left-count ops.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. An append, an unused op or any
// rejected request goes from idle straight to the finish state; a left-count
// query passes through the lookup state first; a locate runs a binary search
// in the search state, which does one read of the cumulative-count memory
// per step, and then passes through lookup. The finish state waits while the
// result channel is stalled. Results go to an output
// register, so a new transaction is taken while the last result is still
// stalled. The tables need no clearing after reset; only entries of stored
// segments are ever used in a result.
module segment_prefix_sum_locator_unit #(
   parameter int MAX_SEGMENTS = spsl_pkg::MAX_SEGMENTS_DEF,
   parameter int COUNT_WIDTH  = spsl_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_seg_length,
   input  logic [31:0] req_char_index,
   input  logic [9:0]  req_seg_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_found_segment,
   output logic [31:0] rsp_offset_in_segment,
   output logic [31:0] rsp_left_count,
   output logic [31:0] rsp_total_count,
   output logic [2:0]  rsp_status
);

   localparam int ADDR_W = $clog2(MAX_SEGMENTS);
   localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int CW     = COUNT_WIDTH;
   localparam int WW     = COUNT_WIDTH + 32;

   logic [CW-1:0] cum_mem [MAX_SEGMENTS];
   logic [CW-1:0] len_mem [MAX_SEGMENTS];
   logic [CW-1:0] cum_rd_ff;
   logic [CW-1:0] len_rd_ff;

   spsl_pkg::fsm_type state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CW-1:0]     total_ff, total_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [CNT_W-1:0]  mid_ff, mid_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [31:0]       idx_ff, idx_in;
   logic              locate_ff, locate_in;
   logic [9:0]        res_found_ff, res_found_in;
   logic [31:0]       res_offset_ff, res_offset_in;
   logic [31:0]       res_left_ff, res_left_in;
   logic [2:0]        res_status_ff, res_status_in;
   logic [9:0]        rsp_found_ff, rsp_found_in;
   logic [31:0]       rsp_offset_ff, rsp_offset_in;
   logic [31:0]       rsp_left_ff, rsp_left_in;
   logic [31:0]       rsp_total_ff, rsp_total_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;

   logic              accept;
   logic              wr_en;
   logic              full;
   logic              ovf;
   logic              past_end;
   logic              bad_seg;
   logic              out_free;
   logic              le;
   logic [WW-1:0]     total_wide;
   logic [WW-1:0]     len_wide;
   logic [WW:0]       sum_wide;
   logic [WW-1:0]     cidx_wide;
   logic [WW-1:0]     idx_wide;
   logic [WW-1:0]     cum_wide;
   logic [WW-1:0]     left_wide;
   logic [WW-1:0]     offset_wide;
   logic [CW-1:0]     left_val;
   logic [CNT_W+9:0]  count_found_w;
   logic [ADDR_W+9:0] sidx_addr_w;
   logic [ADDR_W+9:0] addr_found_w;
   logic [CNT_W-1:0]  lo_step;
   logic [CNT_W-1:0]  hi_step;
   logic [CNT_W-1:0]  mid_step;
   logic [ADDR_W-1:0] rd_addr;

   assign req_stall = reset || (state_ff != spsl_pkg::FSM_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign total_wide    = {32'b0, total_ff};
   assign len_wide      = {{CW{1'b0}}, req_seg_length};
   assign sum_wide      = {1'b0, total_wide} + {1'b0, len_wide};
   assign ovf           = |sum_wide[WW:CW];
   assign full          = (count_ff == CNT_W'(MAX_SEGMENTS));
   assign cidx_wide     = {{CW{1'b0}}, req_char_index};
   assign past_end      = (cidx_wide >= total_wide);
   assign bad_seg       = ({{CNT_W{1'b0}}, req_seg_index} >= {10'b0, count_ff});
   assign count_found_w = {10'b0, count_ff};
   assign sidx_addr_w   = {{ADDR_W{1'b0}}, req_seg_index};
   assign addr_found_w  = {10'b0, addr_ff};
   assign wr_en         = accept && (req_op == spsl_pkg::OP_APPEND) && !full && !ovf;

   // search step: entry at mid_ff was read last cycle
   assign idx_wide = {{CW{1'b0}}, idx_ff};
   assign cum_wide = {32'b0, cum_rd_ff};
   assign le       = (cum_wide <= idx_wide);
   assign lo_step  = le ? (mid_ff + CNT_W'(1)) : lo_ff;
   assign hi_step  = le ? hi_ff : mid_ff;
   assign mid_step = lo_step + ((hi_step - lo_step) >> 1);

   assign left_val    = cum_rd_ff - len_rd_ff;
   assign left_wide   = {32'b0, left_val};
   assign offset_wide = idx_wide - left_wide;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      locate_in     = locate_ff;
      res_found_in  = res_found_ff;
      res_offset_in = res_offset_ff;
      res_left_in   = res_left_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = mid_ff[ADDR_W-1:0];

      case (state_ff)
         spsl_pkg::FSM_IDLE: begin
            if (accept) begin
               res_found_in  = '0;
               res_offset_in = '0;
               res_left_in   = '0;
               res_status_in = spsl_pkg::ST_OK;
               idx_in        = req_char_index;
               state_in      = spsl_pkg::FSM_FINISH;
               case (req_op)
                  spsl_pkg::OP_APPEND: begin
                     if (full) begin
                        res_status_in = spsl_pkg::ST_FULL;
                     end else if (ovf) begin
                        res_status_in = spsl_pkg::ST_OVERFLOW;
                     end else begin
                        res_found_in = count_found_w[9:0];
                        res_left_in  = total_wide[31:0];
                        count_in     = count_ff + CNT_W'(1);
                        total_in     = sum_wide[CW-1:0];
                     end
                  end
                  spsl_pkg::OP_LOCATE: begin
                     if (past_end) begin
                        res_status_in = spsl_pkg::ST_PAST_END;
                     end else begin
                        locate_in = 1'b1;
                        lo_in     = '0;
                        hi_in     = count_ff;
                        mid_in    = count_ff >> 1;
                        rd_addr   = mid_in[ADDR_W-1:0];
                        state_in  = spsl_pkg::FSM_SEARCH;
                     end
                  end
                  spsl_pkg::OP_LEFT: begin
                     if (bad_seg) begin
                        res_status_in = spsl_pkg::ST_BAD_SEG;
                     end else begin
                        locate_in = 1'b0;
                        addr_in   = sidx_addr_w[ADDR_W-1:0];
                        rd_addr   = addr_in;
                        state_in  = spsl_pkg::FSM_LOOKUP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         spsl_pkg::FSM_SEARCH: begin
            lo_in = lo_step;
            hi_in = hi_step;
            if (lo_step < hi_step) begin
               mid_in  = mid_step;
               rd_addr = mid_step[ADDR_W-1:0];
            end else begin
               addr_in  = lo_step[ADDR_W-1:0];
               rd_addr  = addr_in;
               state_in = spsl_pkg::FSM_LOOKUP;
            end
         end
         spsl_pkg::FSM_LOOKUP: begin
            res_found_in  = addr_found_w[9:0];
            res_left_in   = left_wide[31:0];
            res_offset_in = locate_ff ? offset_wide[31:0] : 32'b0;
            state_in      = spsl_pkg::FSM_FINISH;
         end
         spsl_pkg::FSM_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_offset_in = res_offset_ff;
               rsp_left_in   = res_left_ff;
               rsp_total_in  = total_wide[31:0];
               rsp_status_in = res_status_ff;
               state_in      = spsl_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = spsl_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cum_mem[count_ff[ADDR_W-1:0]] <= sum_wide[CW-1:0];
         len_mem[count_ff[ADDR_W-1:0]] <= len_wide[CW-1:0];
      end
      cum_rd_ff <= cum_mem[rd_addr];
      len_rd_ff <= len_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spsl_pkg::FSM_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      locate_ff     <= locate_in;
      res_found_ff  <= res_found_in;
      res_offset_ff <= res_offset_in;
      res_left_ff   <= res_left_in;
      res_status_ff <= res_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_found_segment     = rsp_found_ff;
   assign rsp_offset_in_segment = rsp_offset_ff;
   assign rsp_left_count        = rsp_left_ff;
   assign rsp_total_count       = rsp_total_ff;
   assign rsp_status            = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SEGMENTS))
      else $error("segment count above table depth");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == spsl_pkg::FSM_SEARCH |->
         lo_ff <= mid_ff && mid_ff < hi_ff && hi_ff <= count_ff)
      else $error("search window out of range");

   a_write_bumps_count: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("table write without segment count update");

   a_total_stable: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(!wr_en) |-> total_ff == $past(total_ff))
      else $error("total changed without an append");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == spsl_pkg::FSM_FINISH))
      else $error("result issued outside finish state");
`endif

endmodule
